>>> rtl/amgs_pkg.sv
// Shared types, codes and defaults for the adjacency matrix graph store.
package amgs_pkg;

    // Default sizing handed to the top level parameters.
    localparam int MAX_NODES_DEF  = 16;
    localparam int ATOM_WIDTH_DEF = 32;

    // Fixed port widths.
    localparam int FUNC_W      = 3;
    localparam int NODE_W      = 4;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int STATUS_W    = 2;

    // Command codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD_NODE = 3'd0,
        FUNC_DEL_NODE = 3'd1,
        FUNC_ARC_SET  = 3'd2,
        FUNC_ARC_CLR  = 3'd3,
        FUNC_QUERY    = 3'd4,
        FUNC_WR_WORD  = 3'd5,
        FUNC_RD_WORD  = 3'd6,
        FUNC_CLEAR    = 3'd7
    } func_t;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ARC_WR_A,
        ST_ARC_WR_B,
        ST_QUERY,
        ST_RD_WORD,
        ST_DEL_SRC,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_DEL_END
    } state_t;

    // Control strobes for one memory with per-entry valid bits.
    typedef struct packed {
        logic we;
        logic re;
        logic inv;
        logic clr_all;
    } vmem_ctl_t;

endpackage

>>> rtl/adjacency_matrix_graph_store.sv
// Top level of the adjacency matrix graph store: command sequencer and result register.
//
// The block holds an undirected graph of up to MAX_NODES nodes as a symmetric bit
// matrix (one memory row per node) plus one ATOM_WIDTH-bit word per node, both in
// memories whose per-entry valid bits give an instant clear with no sweep. A command
// is taken when start is high and busy is low; its result appears for exactly one
// cycle with done high, and the receiver cannot stall it, so capture it in that cycle.
// busy falls in the done cycle, so a new command may be issued there. Add node, clear,
// write word and any rejected command finish straight from the execute state; query and
// read word add a memory read; add or remove arc writes both rows in turn; delete node
// walks every row below the last node to move or clear the column of the last node,
// with an extra step first to move the last node down when the deleted node is not the last.
module adjacency_matrix_graph_store #(
    parameter int MAX_NODES  = amgs_pkg::MAX_NODES_DEF,
    parameter int ATOM_WIDTH = amgs_pkg::ATOM_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [amgs_pkg::FUNC_W-1:0]       func,
    input  logic [amgs_pkg::NODE_W-1:0]       node_a,
    input  logic [amgs_pkg::NODE_W-1:0]       node_b,
    input  logic [amgs_pkg::VALUE_W-1:0]      atom_value,
    output logic                              done,
    output logic                              adjacent,
    output logic [amgs_pkg::VALUE_W-1:0]      atom_out,
    output logic [amgs_pkg::COUNT_OUT_W-1:0]  node_count,
    output logic [amgs_pkg::STATUS_W-1:0]     status
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CMP_W = (CNT_W > amgs_pkg::NODE_W) ? CNT_W : amgs_pkg::NODE_W;

    amgs_pkg::state_t state_reg, state_next;
    amgs_pkg::func_t  func_reg, func_next;

    logic [amgs_pkg::NODE_W-1:0]      a_reg, a_next;
    logic [amgs_pkg::NODE_W-1:0]      b_reg, b_next;
    logic [amgs_pkg::VALUE_W-1:0]     val_reg, val_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [IDX_W-1:0]                 j_reg, j_next;
    logic [MAX_NODES-1:0]             r_reg, r_next;
    logic                             done_reg, done_next;
    logic                             adjacent_reg, adjacent_next;
    logic [amgs_pkg::VALUE_W-1:0]     atom_out_reg, atom_out_next;
    logic [amgs_pkg::COUNT_OUT_W-1:0] node_count_reg, node_count_next;
    logic [amgs_pkg::STATUS_W-1:0]    status_reg, status_next;

    // Memory ports.
    amgs_pkg::vmem_ctl_t  row_ctl, word_ctl;
    logic [IDX_W-1:0]     row_waddr, row_raddr, word_waddr, word_raddr;
    logic [MAX_NODES-1:0] row_wdata, row_rd;
    logic [ATOM_WIDTH-1:0] word_wdata, word_rd;

    // Row editor inputs.
    logic [MAX_NODES-1:0] ed_row_in, ed_row_out;
    logic                 ed_set_en, ed_set_val, ed_clr_en;
    logic [IDX_W-1:0]     ed_set_idx, ed_clr_idx;

    // Decoded indexes and range checks.
    logic [IDX_W-1:0] a_idx, b_idx, last_idx, cnt_idx;
    logic             a_ok, ab_ok, moving;

    // Result capture.
    logic                          fin;
    logic [amgs_pkg::STATUS_W-1:0] fin_status;
    logic                          fin_adj;
    logic [amgs_pkg::VALUE_W-1:0]  fin_atom;

    assign a_idx    = IDX_W'(a_reg);
    assign b_idx    = IDX_W'(b_reg);
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign cnt_idx  = IDX_W'(count_reg);
    assign a_ok     = CMP_W'(a_reg) < CMP_W'(count_reg);
    assign ab_ok    = a_ok && (CMP_W'(b_reg) < CMP_W'(count_reg));
    assign moving   = a_idx != last_idx;

    amgs_vmem #(
        .DEPTH (MAX_NODES),
        .WIDTH (MAX_NODES),
        .AW    (IDX_W)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (row_ctl),
        .waddr   (row_waddr),
        .wdata   (row_wdata),
        .raddr   (row_raddr),
        .rd_data (row_rd)
    );

    amgs_vmem #(
        .DEPTH (MAX_NODES),
        .WIDTH (ATOM_WIDTH),
        .AW    (IDX_W)
    ) u_word_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (word_ctl),
        .waddr   (word_waddr),
        .wdata   (word_wdata),
        .raddr   (word_raddr),
        .rd_data (word_rd)
    );

    amgs_row_edit #(
        .N  (MAX_NODES),
        .IW (IDX_W)
    ) u_row_edit (
        .row_in  (ed_row_in),
        .set_en  (ed_set_en),
        .set_idx (ed_set_idx),
        .set_val (ed_set_val),
        .clr_en  (ed_clr_en),
        .clr_idx (ed_clr_idx),
        .row_out (ed_row_out)
    );

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= amgs_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        val_reg        <= val_next;
        j_reg          <= j_next;
        r_reg          <= r_next;
        adjacent_reg   <= adjacent_next;
        atom_out_reg   <= atom_out_next;
        node_count_reg <= node_count_next;
        status_reg     <= status_next;
    end

    // Sequencer: next state, memory commands and row editor selection.
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        j_next          = j_reg;
        r_next          = r_reg;
        adjacent_next   = adjacent_reg;
        atom_out_next   = atom_out_reg;
        node_count_next = node_count_reg;
        status_next     = status_reg;

        row_ctl    = '0;
        word_ctl   = '0;
        row_waddr  = a_idx;
        row_raddr  = a_idx;
        row_wdata  = ed_row_out;
        word_waddr = a_idx;
        word_raddr = a_idx;
        word_wdata = ATOM_WIDTH'(val_reg);

        ed_row_in  = row_rd;
        ed_set_en  = 1'b0;
        ed_set_idx = b_idx;
        ed_set_val = 1'b0;
        ed_clr_en  = 1'b0;
        ed_clr_idx = last_idx;

        fin        = 1'b0;
        fin_status = amgs_pkg::STATUS_DONE;
        fin_adj    = 1'b0;
        fin_atom   = '0;

        unique case (state_reg)
            amgs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    func_next  = amgs_pkg::func_t'(func);
                    a_next     = node_a;
                    b_next     = node_b;
                    val_next   = atom_value;
                    state_next = amgs_pkg::ST_EXEC;
                end
            end

            amgs_pkg::ST_EXEC:
            begin
                unique case (func_reg)
                    amgs_pkg::FUNC_ADD_NODE:
                    begin
                        if (count_reg == CNT_W'(MAX_NODES))
                        begin
                            fin        = 1'b1;
                            fin_status = amgs_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            // The new slot starts with a cleared word and row.
                            word_ctl.inv = 1'b1;
                            word_waddr   = cnt_idx;
                            row_ctl.inv  = 1'b1;
                            row_waddr    = cnt_idx;
                            count_next   = count_reg + CNT_W'(1);
                            fin          = 1'b1;
                        end
                    end
                    amgs_pkg::FUNC_DEL_NODE:
                    begin
                        if (!a_ok)
                        begin
                            fin        = 1'b1;
                            fin_status = amgs_pkg::STATUS_RANGE;
                        end
                        else if (!moving)
                        begin
                            j_next     = '0;
                            state_next = amgs_pkg::ST_DEL_RD;
                        end
                        else
                        begin
                            // Fetch the row and word of the node that moves down.
                            row_ctl.re  = 1'b1;
                            row_raddr   = last_idx;
                            word_ctl.re = 1'b1;
                            word_raddr  = last_idx;
                            state_next  = amgs_pkg::ST_DEL_SRC;
                        end
                    end
                    amgs_pkg::FUNC_ARC_SET, amgs_pkg::FUNC_ARC_CLR:
                    begin
                        if (!ab_ok)
                        begin
                            fin        = 1'b1;
                            fin_status = amgs_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            row_ctl.re = 1'b1;
                            state_next = amgs_pkg::ST_ARC_WR_A;
                        end
                    end
                    amgs_pkg::FUNC_QUERY:
                    begin
                        if (!ab_ok)
                        begin
                            fin        = 1'b1;
                            fin_status = amgs_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            row_ctl.re = 1'b1;
                            state_next = amgs_pkg::ST_QUERY;
                        end
                    end
                    amgs_pkg::FUNC_WR_WORD:
                    begin
                        fin = 1'b1;
                        if (!a_ok)
                        begin
                            fin_status = amgs_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            word_ctl.we = 1'b1;
                        end
                    end
                    amgs_pkg::FUNC_RD_WORD:
                    begin
                        if (!a_ok)
                        begin
                            fin        = 1'b1;
                            fin_status = amgs_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            word_ctl.re = 1'b1;
                            state_next  = amgs_pkg::ST_RD_WORD;
                        end
                    end
                    amgs_pkg::FUNC_CLEAR:
                    begin
                        row_ctl.clr_all  = 1'b1;
                        word_ctl.clr_all = 1'b1;
                        count_next       = '0;
                        fin              = 1'b1;
                    end
                    default:
                    begin
                        fin        = 1'b1;
                        fin_status = amgs_pkg::STATUS_RANGE;
                    end
                endcase
            end

            // Write row a with bit b placed, and fetch row b. When a equals b the
            // fetch sees the old row, and the second write places the same bit.
            amgs_pkg::ST_ARC_WR_A:
            begin
                ed_set_en  = 1'b1;
                ed_set_idx = b_idx;
                ed_set_val = func_reg == amgs_pkg::FUNC_ARC_SET;
                row_ctl.we = 1'b1;
                row_waddr  = a_idx;
                row_ctl.re = 1'b1;
                row_raddr  = b_idx;
                state_next = amgs_pkg::ST_ARC_WR_B;
            end

            amgs_pkg::ST_ARC_WR_B:
            begin
                ed_set_en  = 1'b1;
                ed_set_idx = a_idx;
                ed_set_val = func_reg == amgs_pkg::FUNC_ARC_SET;
                row_ctl.we = 1'b1;
                row_waddr  = b_idx;
                fin        = 1'b1;
            end

            amgs_pkg::ST_QUERY:
            begin
                fin     = 1'b1;
                fin_adj = row_rd[b_idx];
            end

            amgs_pkg::ST_RD_WORD:
            begin
                fin      = 1'b1;
                fin_atom = amgs_pkg::VALUE_W'(word_rd);
            end

            // Build the moved row: its self-loop lands on the freed slot, and the
            // arc to the freed slot is dropped. The word moves down too.
            amgs_pkg::ST_DEL_SRC:
            begin
                ed_set_en   = 1'b1;
                ed_set_idx  = a_idx;
                ed_set_val  = row_rd[last_idx];
                ed_clr_en   = 1'b1;
                r_next      = ed_row_out;
                word_ctl.we = 1'b1;
                word_waddr  = a_idx;
                word_wdata  = word_rd;
                j_next      = '0;
                state_next  = amgs_pkg::ST_DEL_RD;
            end

            // Walk the rows below the last node, one read and one write per row.
            amgs_pkg::ST_DEL_RD:
            begin
                if (j_reg == last_idx)
                begin
                    state_next = amgs_pkg::ST_DEL_END;
                end
                else
                begin
                    row_ctl.re = 1'b1;
                    row_raddr  = j_reg;
                    state_next = amgs_pkg::ST_DEL_WR;
                end
            end

            amgs_pkg::ST_DEL_WR:
            begin
                ed_clr_en = 1'b1;
                if (moving && (j_reg == a_idx))
                begin
                    ed_row_in = r_reg;
                end
                else
                begin
                    ed_set_en  = moving;
                    ed_set_idx = a_idx;
                    ed_set_val = r_reg[j_reg];
                end
                row_ctl.we = 1'b1;
                row_waddr  = j_reg;
                j_next     = j_reg + IDX_W'(1);
                state_next = amgs_pkg::ST_DEL_RD;
            end

            amgs_pkg::ST_DEL_END:
            begin
                row_ctl.inv  = 1'b1;
                row_waddr    = last_idx;
                word_ctl.inv = 1'b1;
                word_waddr   = last_idx;
                count_next   = count_reg - CNT_W'(1);
                fin          = 1'b1;
            end

            default:
            begin
                state_next = amgs_pkg::ST_IDLE;
            end
        endcase

        // Capture the result word as the command finishes.
        done_next = fin;
        if (fin)
        begin
            state_next      = amgs_pkg::ST_IDLE;
            adjacent_next   = fin_adj;
            atom_out_next   = fin_atom;
            status_next     = fin_status;
            node_count_next = amgs_pkg::COUNT_OUT_W'(count_next);
        end
    end

    assign busy       = state_reg != amgs_pkg::ST_IDLE;
    assign done       = done_reg;
    assign adjacent   = adjacent_reg;
    assign atom_out   = atom_out_reg;
    assign node_count = node_count_reg;
    assign status     = status_reg;

    // A result only follows a command that was being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg != amgs_pkg::ST_IDLE))
        else $error("result strobe without a command in progress");

    // The node count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_NODES))
        else $error("node count beyond capacity");

    // An accepted command holds the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // A full report only comes when the graph holds every slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == amgs_pkg::STATUS_FULL))
            |-> (node_count == amgs_pkg::COUNT_OUT_W'(MAX_NODES)))
        else $error("full status while slots remain");

    // The delete walk never passes the last node.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == amgs_pkg::ST_DEL_RD) || (state_reg == amgs_pkg::ST_DEL_WR))
            |-> (j_reg <= last_idx))
        else $error("delete walk ran past the last node");

endmodule

>>> rtl/amgs_vmem.sv
// Single write, single read memory with per-entry valid bits; invalid entries read as zero.
module amgs_vmem #(
    parameter int DEPTH = amgs_pkg::MAX_NODES_DEF,
    parameter int WIDTH = amgs_pkg::ATOM_WIDTH_DEF,
    parameter int AW    = $clog2(amgs_pkg::MAX_NODES_DEF)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  amgs_pkg::vmem_ctl_t ctl,
    input  logic [AW-1:0]       waddr,
    input  logic [WIDTH-1:0]    wdata,
    input  logic [AW-1:0]       raddr,
    output logic [WIDTH-1:0]    rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    // Storage array and registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    // Valid bits: a write marks an entry, an invalidate or a clear drops it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (ctl.we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            else if (ctl.inv)
            begin
                valid_reg[waddr] <= 1'b0;
            end
            if (ctl.re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    // An entry that was never written or was dropped reads as zero.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/amgs_row_edit.sv
// Shared row bit editor: places one bit, then clears another, in an adjacency row.
module amgs_row_edit #(
    parameter int N  = amgs_pkg::MAX_NODES_DEF,
    parameter int IW = $clog2(amgs_pkg::MAX_NODES_DEF)
) (
    input  logic [N-1:0]  row_in,
    input  logic          set_en,
    input  logic [IW-1:0] set_idx,
    input  logic          set_val,
    input  logic          clr_en,
    input  logic [IW-1:0] clr_idx,
    output logic [N-1:0]  row_out
);

    // The clear is applied last so that it wins when both name the same bit.
    always_comb
    begin
        row_out = row_in;
        if (set_en)
        begin
            row_out[set_idx] = set_val;
        end
        if (clr_en)
        begin
            row_out[clr_idx] = 1'b0;
        end
    end

endmodule
